>>> rtl/cca3_pkg.sv
// ----------------------------------------------------------------------------
// cca3_pkg
// Shared types, codes and the palette for the 3D cyclic automaton unit.
// ----------------------------------------------------------------------------
package cca3_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_ADV   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;
  localparam logic [1:0] REG_THRESH = 2'd3;

  localparam logic [3:0] LAST_STATE = 4'd11;

  // neighbor offset digits {dz, dy, dx}, each 0..2 meaning -1..+1
  localparam logic [5:0] D_FIRST  = 6'b00_00_00;
  localparam logic [5:0] D_CENTER = 6'b01_01_01;
  localparam logic [5:0] D_LAST   = 6'b10_10_10;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_MOD,
    S_RD,
    S_RDW,
    S_ADV_ISS,
    S_ADV_DRN,
    S_ADV_WB,
    S_OUT
  } cca3_state_t;

  typedef struct packed {
    logic vld;
    logic center;
  } cca3_rd_tag_t;

  function automatic logic [5:0] d_inc(input logic [5:0] d);
    logic [5:0] r;
    r = d;
    if (d[1:0] != 2'd2) begin
      r[1:0] = d[1:0] + 2'd1;
    end else begin
      r[1:0] = 2'd0;
      if (d[3:2] != 2'd2) begin
        r[3:2] = d[3:2] + 2'd1;
      end else begin
        r[3:2] = 2'd0;
        r[5:4] = (d[5:4] == 2'd2) ? 2'd0 : d[5:4] + 2'd1;
      end
    end
    return r;
  endfunction

  function automatic logic [3:0] succ_state(input logic [3:0] s);
    return (s >= LAST_STATE) ? 4'd0 : s + 4'd1;
  endfunction

  function automatic logic [23:0] palette(input logic [3:0] s);
    logic [23:0] c;
    unique case (s)
      4'd0:    c = {8'd255, 8'd0,   8'd0};
      4'd1:    c = {8'd255, 8'd128, 8'd0};
      4'd2:    c = {8'd255, 8'd255, 8'd0};
      4'd3:    c = {8'd128, 8'd255, 8'd0};
      4'd4:    c = {8'd0,   8'd255, 8'd0};
      4'd5:    c = {8'd0,   8'd255, 8'd128};
      4'd6:    c = {8'd0,   8'd255, 8'd255};
      4'd7:    c = {8'd0,   8'd128, 8'd255};
      4'd8:    c = {8'd0,   8'd0,   8'd255};
      4'd9:    c = {8'd128, 8'd0,   8'd255};
      4'd10:   c = {8'd255, 8'd0,   8'd255};
      default: c = {8'd255, 8'd0,   8'd128};
    endcase
    return c;
  endfunction

endpackage

>>> rtl/cca3_grid_mem.sv
// ----------------------------------------------------------------------------
// cca3_grid_mem
// Single write, single registered read cell store holding both grid banks.
// ----------------------------------------------------------------------------
module cca3_grid_mem #(
  parameter int AW = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [3:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [3:0]    rdata
);

  logic [3:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/cca3_nbr_unit.sv
// ----------------------------------------------------------------------------
// cca3_nbr_unit
// Shared compare/count unit: latches the center cell, counts neighbors in
// the successor state and forms the cell's next state.
// ----------------------------------------------------------------------------
module cca3_nbr_unit (
  input  logic                  clk,
  input  cca3_pkg::cca3_rd_tag_t rd_tag,
  input  logic [3:0]            rd_data,
  input  logic [4:0]            threshold,
  output logic [3:0]            new_state
);
  import cca3_pkg::*;

  logic [3:0] cur_r;
  logic [4:0] cnt_r;
  logic [3:0] succ;

  assign succ = succ_state(cur_r);

  always_ff @(posedge clk) begin
    if (rd_tag.vld) begin
      if (rd_tag.center) begin
        cur_r <= rd_data;
        cnt_r <= '0;
      end else if (rd_data == succ) begin
        cnt_r <= cnt_r + 5'd1;
      end
    end
  end

  assign new_state = (cnt_r >= threshold) ? succ : cur_r;

endmodule

>>> rtl/cyclic_cellular_automaton_3d_unit.sv
// ----------------------------------------------------------------------------
// cyclic_cellular_automaton_3d_unit
// 3D toroidal cyclic automaton, 12 states, Moore neighborhood, two banks.
//
//   channel  dir  handshake            payload
//   in_      in   in_valid/in_stall    op, x/y/z_coord, cell_value
//   out_     out  out_valid/out_stall  cell_state, red, green, blue
//   cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Write and read wrap the coordinates into range by repeated subtraction.
// Advance: 27 reads per active cell on the single read port.
// After reset a clear pass zeroes all 2**(XW+YW+ZW) cells of bank A; no transfer.
// in_stall is high outside S_IDLE (clear pass or an item in work); one result may wait at the output.
// ----------------------------------------------------------------------------
module cyclic_cellular_automaton_3d_unit #(
  parameter int MAX_X = 16,
  parameter int MAX_Y = 16,
  parameter int MAX_Z = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_op,
  input  logic [3:0] in_x_coord,
  input  logic [3:0] in_y_coord,
  input  logic [3:0] in_z_coord,
  input  logic [3:0] in_cell_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_cell_state,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data
);
  import cca3_pkg::*;

  localparam int XW  = $clog2(MAX_X);
  localparam int YW  = $clog2(MAX_Y);
  localparam int ZW  = $clog2(MAX_Z);
  localparam int MW0 = (XW > YW) ? XW : YW;
  localparam int MW1 = (MW0 > ZW) ? MW0 : ZW;
  localparam int CW  = ((MW1 > 4) ? MW1 : 4) + 1;
  localparam int GW  = XW + YW + ZW;
  localparam int AW  = GW + 1;

  cca3_state_t state_r, state_nxt;

  logic [4:0] size_x_r, size_y_r, size_z_r, thresh_r;
  logic       bank_r;
  logic [GW-1:0] clr_r;
  logic [1:0] op_r;
  logic [3:0] val_r;
  logic [CW-1:0] cx_r, cy_r, cz_r;
  logic [5:0] d_r;
  logic       center_r;
  logic [3:0] res_r;
  cca3_rd_tag_t tag_r;
  logic       out_valid_r;
  logic [3:0] out_cell_r;
  logic [23:0] out_rgb_r;

  logic [CW-1:0] nx, ny, nz;
  logic          mod_done, last_cell;
  logic [5:0]    d_step, d_nxt;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [3:0]    wdata, rdata, new_state;
  logic          out_free;

  function automatic logic [CW-1:0] eff_size(input logic [4:0] v, input int mx);
    logic [CW-1:0] e;
    if (v == 5'd0) e = CW'(1);
    else if (CW'(v) > CW'(mx)) e = CW'(mx);
    else e = CW'(v);
    return e;
  endfunction

  function automatic logic [CW-1:0] wrap(input logic [CW-1:0] c, input logic [1:0] d,
                                         input logic [CW-1:0] n);
    logic [CW-1:0] r;
    if (d == 2'd0) r = (c == '0) ? n - CW'(1) : c - CW'(1);
    else if (d == 2'd2) r = (c + CW'(1) == n) ? '0 : c + CW'(1);
    else r = c;
    return r;
  endfunction

  function automatic logic [AW-1:0] addr(input logic b, input logic [CW-1:0] x,
                                         input logic [CW-1:0] y, input logic [CW-1:0] z);
    return {b, z[ZW-1:0], y[YW-1:0], x[XW-1:0]};
  endfunction

  assign nx = eff_size(size_x_r, MAX_X);
  assign ny = eff_size(size_y_r, MAX_Y);
  assign nz = eff_size(size_z_r, MAX_Z);

  assign mod_done  = (cx_r < nx) && (cy_r < ny) && (cz_r < nz);
  assign last_cell = (cx_r == nx - CW'(1)) && (cy_r == ny - CW'(1)) && (cz_r == nz - CW'(1));
  assign d_step    = d_inc(d_r);
  assign d_nxt     = (d_step == D_CENTER) ? d_inc(d_step) : d_step;
  assign out_free  = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:     if (clr_r == '1) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) state_nxt = (in_op == OP_ADV) ? S_ADV_ISS : S_MOD;
      end
      S_MOD: begin
        if (mod_done) state_nxt = (op_r == OP_READ) ? S_RD : S_OUT;
      end
      S_RD:      state_nxt = S_RDW;
      S_RDW:     state_nxt = S_OUT;
      S_ADV_ISS: if (!center_r && d_r == D_LAST) state_nxt = S_ADV_DRN;
      S_ADV_DRN: state_nxt = S_ADV_WB;
      S_ADV_WB:  state_nxt = last_cell ? S_OUT : S_ADV_ISS;
      S_OUT:     if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    we    = 1'b0;
    waddr = addr(bank_r, cx_r, cy_r, cz_r);
    wdata = (val_r > LAST_STATE) ? LAST_STATE : val_r;
    raddr = addr(bank_r, cx_r, cy_r, cz_r);
    unique case (state_r)
      S_CLR: begin
        we    = 1'b1;
        waddr = {1'b0, clr_r};
        wdata = 4'd0;
      end
      S_MOD:     we = mod_done && (op_r == OP_WRITE);
      S_ADV_ISS: begin
        if (!center_r) begin
          raddr = addr(bank_r, wrap(cx_r, d_r[1:0], nx), wrap(cy_r, d_r[3:2], ny),
                       wrap(cz_r, d_r[5:4], nz));
        end
      end
      S_ADV_WB: begin
        we    = 1'b1;
        waddr = addr(!bank_r, cx_r, cy_r, cz_r);
        wdata = new_state;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      size_x_r    <= 5'd16;
      size_y_r    <= 5'd16;
      size_z_r    <= 5'd16;
      thresh_r    <= 5'd3;
      bank_r      <= 1'b0;
      clr_r       <= '0;
      tag_r       <= '0;
      out_valid_r <= 1'b0;
      center_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tag_r.vld    <= (state_r == S_ADV_ISS);
      tag_r.center <= center_r;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SIZE_X: size_x_r <= cfg_data;
          REG_SIZE_Y: size_y_r <= cfg_data;
          REG_SIZE_Z: size_z_r <= cfg_data;
          REG_THRESH: thresh_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall && state_r != S_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLR: clr_r <= clr_r + GW'(1);
        S_IDLE: begin
          if (in_valid) begin
            op_r     <= in_op;
            val_r    <= in_cell_value;
            res_r    <= 4'd0;
            d_r      <= D_FIRST;
            center_r <= 1'b1;
            if (in_op == OP_ADV) begin
              cx_r <= '0;
              cy_r <= '0;
              cz_r <= '0;
            end else begin
              cx_r <= CW'(in_x_coord);
              cy_r <= CW'(in_y_coord);
              cz_r <= CW'(in_z_coord);
            end
          end
        end
        S_MOD: begin
          if (cx_r >= nx) cx_r <= cx_r - nx;
          if (cy_r >= ny) cy_r <= cy_r - ny;
          if (cz_r >= nz) cz_r <= cz_r - nz;
          if (mod_done && op_r == OP_WRITE) res_r <= wdata;
        end
        S_RDW: res_r <= (rdata > LAST_STATE) ? LAST_STATE : rdata;
        S_ADV_ISS: begin
          if (center_r) center_r <= 1'b0;
          else d_r <= d_nxt;
        end
        S_ADV_WB: begin
          d_r      <= D_FIRST;
          center_r <= 1'b1;
          if (last_cell) begin
            bank_r <= !bank_r;
          end else if (cx_r != nx - CW'(1)) begin
            cx_r <= cx_r + CW'(1);
          end else begin
            cx_r <= '0;
            if (cy_r != ny - CW'(1)) begin
              cy_r <= cy_r + CW'(1);
            end else begin
              cy_r <= '0;
              cz_r <= cz_r + CW'(1);
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_cell_r  <= res_r;
            out_rgb_r   <= (op_r == OP_WRITE || op_r == OP_READ) ? palette(res_r) : 24'd0;
          end
        end
        default: ;
      endcase
    end
  end

  cca3_grid_mem #(.AW(AW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  cca3_nbr_unit u_nbr (
    .clk       (clk),
    .rd_tag    (tag_r),
    .rd_data   (rdata),
    .threshold (thresh_r),
    .new_state (new_state)
  );

  assign out_valid      = out_valid_r;
  assign out_cell_state = out_cell_r;
  assign out_red        = out_rgb_r[23:16];
  assign out_green      = out_rgb_r[15:8];
  assign out_blue       = out_rgb_r[7:0];

`ifndef ASSERT_OFF
  a_clr_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> in_stall)
    else $error("input taken during clear pass");

  a_no_write_while_reading: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADV_ISS) |-> !we)
    else $error("grid write during neighbor read sweep");

  a_tag_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
    tag_r.vld |-> $past(state_r) == S_ADV_ISS)
    else $error("read tag without issue");

  a_result_one_per_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_free) |=> out_valid_r && state_r == S_IDLE)
    else $error("result not loaded");
`endif

endmodule

>>> test/tb_cyclic_cellular_automaton_3d_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cyclic_cellular_automaton_3d_unit
// Self-checking bench for the 3D cyclic automaton unit. Cell writes, reads,
// generation steps and unused ops are checked against a behavioral grid model
// under random gaps and stalls, over several grid sizes and thresholds.
// ----------------------------------------------------------------------------
module tb_cyclic_cellular_automaton_3d_unit;
  import cca3_pkg::*;

  localparam int NX = 16;
  localparam int NY = 16;
  localparam int NZ = 16;
  localparam int NCELL = NX * NY * NZ;

  typedef struct packed {
    logic [3:0] state;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cell_color_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_op = OP_NONE;
  logic [3:0] in_x_coord = '0;
  logic [3:0] in_y_coord = '0;
  logic [3:0] in_z_coord = '0;
  logic [3:0] in_cell_value = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] out_cell_state;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = REG_SIZE_X;
  logic [4:0] cfg_data = '0;

  cyclic_cellular_automaton_3d_unit #(.MAX_X(NX), .MAX_Y(NY), .MAX_Z(NZ)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // grid model
  logic [3:0]  bank [2][NCELL];
  logic        bank_sel;
  logic [4:0]  reg_sx, reg_sy, reg_sz, reg_thr;
  cell_color_t pending_colors[$];
  int          n_err, n_items, n_adv, n_rd, n_wr;
  int          hold_left;
  bit          no_stall;

  function automatic int eff(input logic [4:0] v, input int mx);
    if (v == 0) return 1;
    if (v > mx) return mx;
    return v;
  endfunction

  function automatic cell_color_t colorize(input logic [3:0] s);
    cell_color_t c;
    c.state = s;
    case (s)
      0: {c.red, c.green, c.blue} = {8'd255, 8'd0,   8'd0};
      1: {c.red, c.green, c.blue} = {8'd255, 8'd128, 8'd0};
      2: {c.red, c.green, c.blue} = {8'd255, 8'd255, 8'd0};
      3: {c.red, c.green, c.blue} = {8'd128, 8'd255, 8'd0};
      4: {c.red, c.green, c.blue} = {8'd0,   8'd255, 8'd0};
      5: {c.red, c.green, c.blue} = {8'd0,   8'd255, 8'd128};
      6: {c.red, c.green, c.blue} = {8'd0,   8'd255, 8'd255};
      7: {c.red, c.green, c.blue} = {8'd0,   8'd128, 8'd255};
      8: {c.red, c.green, c.blue} = {8'd0,   8'd0,   8'd255};
      9: {c.red, c.green, c.blue} = {8'd128, 8'd0,   8'd255};
      10: {c.red, c.green, c.blue} = {8'd255, 8'd0,  8'd255};
      default: {c.red, c.green, c.blue} = {8'd255, 8'd0, 8'd128};
    endcase
    return c;
  endfunction

  function automatic int cidx(input int x, input int y, input int z);
    return x + NX * (y + NY * z);
  endfunction

  task automatic step_generation();
    int nx, ny, nz, cnt, cur, nxt;
    nx = eff(reg_sx, NX);
    ny = eff(reg_sy, NY);
    nz = eff(reg_sz, NZ);
    for (int z = 0; z < nz; z++)
      for (int y = 0; y < ny; y++)
        for (int x = 0; x < nx; x++) begin
          cur = bank[bank_sel][cidx(x, y, z)];
          nxt = (cur + 1) % 12;
          cnt = 0;
          for (int dz = -1; dz <= 1; dz++)
            for (int dy = -1; dy <= 1; dy++)
              for (int dx = -1; dx <= 1; dx++)
                if (!(dx == 0 && dy == 0 && dz == 0))
                  if (bank[bank_sel][cidx((x + nx + dx) % nx, (y + ny + dy) % ny,
                                          (z + nz + dz) % nz)] == nxt)
                    cnt++;
          bank[!bank_sel][cidx(x, y, z)] = (cnt >= reg_thr) ? nxt[3:0] : cur[3:0];
        end
    bank_sel = !bank_sel;
  endtask

  task automatic predict_cell(input logic [1:0] op, input logic [3:0] x, input logic [3:0] y,
                              input logic [3:0] z, input logic [3:0] v);
    int i;
    logic [3:0] s;
    i = cidx(x % eff(reg_sx, NX), y % eff(reg_sy, NY), z % eff(reg_sz, NZ));
    case (op)
      OP_WRITE: begin
        s = (v > LAST_STATE) ? LAST_STATE : v;
        bank[bank_sel][i] = s;
        pending_colors.push_back(colorize(s));
        n_wr++;
      end
      OP_READ: begin
        pending_colors.push_back(colorize(bank[bank_sel][i]));
        n_rd++;
      end
      OP_ADV: begin
        step_generation();
        pending_colors.push_back('0);
        n_adv++;
      end
      default: pending_colors.push_back('0);
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_cell(input logic [1:0] op, input logic [3:0] x, input logic [3:0] y,
                           input logic [3:0] z, input logic [3:0] v, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_x_coord    <= x;
    in_y_coord    <= y;
    in_z_coord    <= z;
    in_cell_value <= v;
    do @(posedge clk); while (in_stall);
    predict_cell(op, x, y, z, v);
    n_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SIZE_X: reg_sx = val;
      REG_SIZE_Y: reg_sy = val;
      REG_SIZE_Z: reg_sz = val;
      default:    reg_thr = val;
    endcase
  endtask

  task automatic set_grid(input logic [4:0] sx, input logic [4:0] sy, input logic [4:0] sz,
                          input logic [4:0] thr);
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
    write_reg(REG_THRESH, thr);
  endtask

  // full-size generation first so both banks hold defined data everywhere
  task automatic test_full_grid();
    send_cell(OP_WRITE, 4'd0, 4'd0, 4'd0, 4'd15, 0);
    send_cell(OP_WRITE, 4'd15, 4'd15, 4'd15, 4'd1, 1);
    send_cell(OP_WRITE, 4'd1, 4'd0, 4'd0, 4'd1, 0);
    send_cell(OP_WRITE, 4'd0, 4'd1, 4'd0, 4'd1, 0);
    send_cell(OP_ADV, 4'd0, 4'd0, 4'd0, 4'd0, 2);
    send_cell(OP_READ, 4'd0, 4'd0, 4'd0, 4'd0, 0);
    send_cell(OP_READ, 4'd15, 4'd15, 4'd15, 4'd0, 0);
    send_cell(OP_NONE, 4'd15, 4'd15, 4'd15, 4'd15, 0);
    send_cell(OP_ADV, 4'd0, 4'd0, 4'd0, 4'd0, 0);
  endtask

  task automatic test_size_extremes();
    set_grid(5'd31, 5'd0, 5'd1, 5'd3);
    for (int s = 0; s < 12; s++)
      send_cell(OP_WRITE, 4'(s + 3), 4'(s), 4'(15 - s), 4'(s), 0);
    send_cell(OP_READ, 4'd14, 4'd9, 4'd7, 4'd0, 0);
    send_cell(OP_ADV, 4'd0, 4'd0, 4'd0, 4'd0, 0);
    send_cell(OP_READ, 4'd4, 4'd0, 4'd0, 4'd0, 1);
    set_grid(5'd16, 5'd1, 5'd0, 5'd3);
    send_cell(OP_ADV, 4'd0, 4'd0, 4'd0, 4'd0, 0);
    send_cell(OP_READ, 4'd5, 4'd0, 4'd0, 4'd0, 0);
  endtask

  task automatic test_threshold_extremes();
    set_grid(5'd2, 5'd2, 5'd2, 5'd0);
    send_cell(OP_WRITE, 4'd0, 4'd0, 4'd0, 4'd11, 0);
    send_cell(OP_ADV, 4'd0, 4'd0, 4'd0, 4'd0, 0);
    send_cell(OP_READ, 4'd0, 4'd0, 4'd0, 4'd0, 0);
    send_cell(OP_READ, 4'd1, 4'd1, 4'd1, 4'd0, 0);
    write_reg(REG_THRESH, 5'd31);
    send_cell(OP_ADV, 4'd0, 4'd0, 4'd0, 4'd0, 0);
    send_cell(OP_READ, 4'd0, 4'd1, 4'd0, 4'd0, 0);
    write_reg(REG_THRESH, 5'd26);
    send_cell(OP_ADV, 4'd0, 4'd0, 4'd0, 4'd0, 0);
    send_cell(OP_READ, 4'd1, 4'd0, 4'd1, 4'd0, 0);
  endtask

  task automatic test_backpressure();
    set_grid(5'd3, 5'd3, 5'd2, 5'd2);
    hold_left = 3500;
    for (int i = 0; i < 6; i++)
      send_cell(2'($urandom_range(0, 3)), 4'($urandom), 4'($urandom), 4'($urandom),
                4'($urandom), 0);
    drain();
  endtask

  task automatic test_random(input int count);
    logic [1:0] op;
    int r;
    for (int i = 0; i < count; i++) begin
      if (i % 30 == 0) begin
        r = $urandom_range(0, 9);
        set_grid(5'($urandom_range(1, 4)), 5'($urandom_range(1, 4)),
                 (r == 0) ? 5'd0 : 5'($urandom_range(1, 3)),
                 (r == 1) ? 5'($urandom_range(27, 31)) : 5'($urandom_range(0, 8)));
        no_stall = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      op = (r < 40) ? OP_WRITE : (r < 80) ? OP_READ : (r < 92) ? OP_ADV : OP_NONE;
      send_cell(op, 4'($urandom), 4'($urandom), 4'($urandom),
                ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15))
                                            : 4'($urandom_range(0, 11)),
                no_stall ? 0 : pick_gap());
    end
    no_stall = 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (no_stall) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 30) ||
                   (out_stall && $urandom_range(0, 99) < 40);
    end
  end

  always @(posedge clk) begin
    cell_color_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_colors.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("ERROR: unexpected result transfer at %0t", $realtime);
      end else begin
        want = pending_colors.pop_front();
        if (out_cell_state !== want.state || out_red !== want.red ||
            out_green !== want.green || out_blue !== want.blue) begin
          n_err++;
          if (n_err <= 10)
            $display("ERROR: state/r/g/b exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     want.state, want.red, want.green, want.blue,
                     out_cell_state, out_red, out_green, out_blue);
        end
      end
    end
  end

  initial begin
    bank_sel = 1'b0;
    for (int i = 0; i < NCELL; i++) begin
      bank[0][i] = '0;
      bank[1][i] = '0;
    end
    reg_sx = 5'd16;
    reg_sy = 5'd16;
    reg_sz = 5'd16;
    reg_thr = 5'd3;
    n_err = 0;
    n_items = 0;
    n_adv = 0;
    n_rd = 0;
    n_wr = 0;
    hold_left = 0;
    no_stall = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_full_grid();
    test_size_extremes();
    test_threshold_extremes();
    test_backpressure();
    test_random(100);
    drain();
    repeat (60) @(posedge clk);
    if (pending_colors.size() != 0) begin
      n_err++;
      $display("ERROR: %0d results never arrived", pending_colors.size());
    end
    $display("Covered %0d transfers: %0d writes, %0d reads, %0d generations,",
             n_items, n_wr, n_rd, n_adv);
    $display("grid sizes 1..16 with clamping, thresholds 0..31; %0d mismatches", n_err);
    if (n_err == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("ERROR: timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> sim.f
rtl/cca3_pkg.sv
rtl/cca3_grid_mem.sv
rtl/cca3_nbr_unit.sv
rtl/cyclic_cellular_automaton_3d_unit.sv
test/tb_cyclic_cellular_automaton_3d_unit.sv
